// ===== design/prfd_pkg.sv =====
// Shared constants, types and helper functions of the palette run-length frame decoder.
package prfd_pkg;

	// Storage and frame limits
	localparam int PALETTE_DEPTH = 256;
	localparam int MAX_WIDTH     = 1024;
	localparam int MAX_HEIGHT    = 1024;

	// Fixed field widths of the item, span and configuration payloads
	localparam int FUNC_W  = 2;
	localparam int BYTE_W  = 8;
	localparam int COLOR_W = 16;
	localparam int NENT_W  = 9;
	localparam int DIM_W   = 11;
	localparam int START_W = 20;
	localparam int COUNT_W = 21;

	// Derived widths
	localparam int PAL_AW = $clog2(PALETTE_DEPTH);
	localparam int WC_W   = $clog2(MAX_WIDTH + 1);
	localparam int HC_W   = $clog2(MAX_HEIGHT + 1);
	localparam int POS_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

	// Reset values of the configuration registers
	localparam logic [NENT_W-1:0]  RST_PAL_ENTRIES = NENT_W'(256);
	localparam logic [DIM_W-1:0]   RST_WIDTH       = DIM_W'(240);
	localparam logic [DIM_W-1:0]   RST_HEIGHT      = DIM_W'(240);
	localparam logic [COLOR_W-1:0] RST_FILL_COLOR  = '0;

	// Command queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PAL_ENTRIES = 3'd0,
		CFG_FRAME_WIDTH = 3'd1,
		CFG_FRAME_HEIGHT = 3'd2,
		CFG_ZERO_BG     = 3'd3,
		CFG_FILL_COLOR  = 3'd4
	} cfg_idx_t;

	// Item function codes
	localparam logic [FUNC_W-1:0] FUNC_PAL_WRITE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_RUN       = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FRAME_END = 2'd2;

	// Command kinds carried through the queue
	typedef enum logic [1:0] {
		OP_PAL,
		OP_RUN,
		OP_END
	} op_kind_t;

	typedef struct packed {
		op_kind_t               kind;
		logic [BYTE_W-1:0]      addr;
		logic [COLOR_W-1:0]     color;
		logic [BYTE_W-1:0]      run;
		logic                   use_bg;
	} op_t;

	// Settings seen by front and back
	typedef struct packed {
		logic [NENT_W-1:0]  pal_n;
		logic               zero_bg;
		logic [COLOR_W-1:0] fill_color;
		logic [POS_W-1:0]   total;
	} cfg_t;

	// Exchange high and low byte of an RGB565 colour
	function automatic logic [COLOR_W-1:0] swap16(input logic [COLOR_W-1:0] c);
		return {c[7:0], c[15:8]};
	endfunction

	// Clamp a width to 1 .. MAX_WIDTH
	function automatic logic [WC_W-1:0] clamp_width(input logic [DIM_W-1:0] v);
		logic [WC_W-1:0] r;
		if (v == '0) begin
			r = WC_W'(1);
		end else if (32'(v) > MAX_WIDTH) begin
			r = WC_W'(MAX_WIDTH);
		end else begin
			r = WC_W'(v);
		end
		return r;
	endfunction

	// Clamp a height to 1 .. MAX_HEIGHT
	function automatic logic [HC_W-1:0] clamp_height(input logic [DIM_W-1:0] v);
		logic [HC_W-1:0] r;
		if (v == '0) begin
			r = HC_W'(1);
		end else if (32'(v) > MAX_HEIGHT) begin
			r = HC_W'(MAX_HEIGHT);
		end else begin
			r = HC_W'(v);
		end
		return r;
	endfunction

	// Clamp the palette size to 1 .. PALETTE_DEPTH
	function automatic logic [NENT_W-1:0] clamp_entries(input logic [NENT_W-1:0] v);
		logic [NENT_W-1:0] r;
		if (v == '0) begin
			r = NENT_W'(1);
		end else if (32'(v) > PALETTE_DEPTH) begin
			r = NENT_W'(PALETTE_DEPTH);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Pixels in the frame for given line width and line count
	function automatic logic [POS_W-1:0] frame_pixels(input logic [DIM_W-1:0] w,
			input logic [DIM_W-1:0] h);
		logic [WC_W+HC_W-1:0] p;
		p = (WC_W+HC_W)'(clamp_width(w)) * (WC_W+HC_W)'(clamp_height(h));
		return POS_W'(p);
	endfunction

endpackage

// ===== design/prfd_if.sv =====
// Channel interfaces of the decoder: item input, span output and configuration write.
interface prfd_item_if;
	import prfd_pkg::*;
	logic               valid;
	logic               ready;
	logic [FUNC_W-1:0]  func;
	logic [BYTE_W-1:0]  entry_slot;
	logic [COLOR_W-1:0] entry_color;
	logic [BYTE_W-1:0]  run_count;
	logic [BYTE_W-1:0]  pixel_index;
	modport source(output valid, func, entry_slot, entry_color, run_count, pixel_index,
		input ready);
	modport sink(input valid, func, entry_slot, entry_color, run_count, pixel_index,
		output ready);
endinterface

interface prfd_span_if;
	import prfd_pkg::*;
	logic               valid;
	logic               ready;
	logic [START_W-1:0] span_start;
	logic [COUNT_W-1:0] span_count;
	logic [COLOR_W-1:0] span_color;
	logic               frame_end;
	modport source(output valid, span_start, span_count, span_color, frame_end,
		input ready);
	modport sink(input valid, span_start, span_count, span_color, frame_end,
		output ready);
endinterface

interface prfd_cfg_if;
	import prfd_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] wdata;
	modport source(output valid, index, wdata, input ready);
	modport sink(input valid, index, wdata, output ready);
endinterface

// ===== design/palette_rle_frame_decoder.sv =====
// A span is offered after its item has passed the queue, then two stages (stage 1 and the output register).
// Throughput: one item per cycle while the command queue has room.
// A four-entry command queue lets the front keep taking items while the output stalls.
// Reset clears the queue, the stage valids and the frame position, and loads the register
// defaults; palette contents stay undefined until written.
module palette_rle_frame_decoder
	import prfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	prfd_cfg_if.sink    cfg,
	prfd_item_if.sink   item,
	prfd_span_if.source span
);

	cfg_t regs;
	logic push_valid;
	logic push_ready;
	op_t  push_data;
	logic pop_valid;
	logic pop_ready;
	op_t  pop_data;

	// Configuration registers
	prfd_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// Classify items
	prfd_front u_front (
		.item    (item),
		.regs    (regs),
		.q_ready (push_ready),
		.q_valid (push_valid),
		.q_data  (push_data)
	);

	// Decouple front and back
	prfd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// Execute commands and emit spans
	prfd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.regs    (regs),
		.q_valid (pop_valid),
		.q_ready (pop_ready),
		.q_data  (pop_data),
		.span    (span)
	);

endmodule

// ===== design/prfd_cfg.sv =====
// Configuration register file with the derived palette size and frame pixel total.
module prfd_cfg
	import prfd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	prfd_cfg_if.sink     cfg,
	output cfg_t         regs
);

	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic [NENT_W-1:0]  pal_n_q;
	logic               zero_bg_q;
	logic [COLOR_W-1:0] fill_color_q;
	logic [POS_W-1:0]   total_q;
	logic               wr;

	// Always take a write transaction
	assign cfg.ready = 1'b1;
	assign wr = cfg.valid;

	// Store registers; refresh the pixel total with the register being written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= RST_WIDTH;
			height_q     <= RST_HEIGHT;
			pal_n_q      <= clamp_entries(RST_PAL_ENTRIES);
			zero_bg_q    <= 1'b0;
			fill_color_q <= RST_FILL_COLOR;
			total_q      <= frame_pixels(RST_WIDTH, RST_HEIGHT);
		end else if (wr) begin
			unique case (cfg.index)
				CFG_PAL_ENTRIES: begin
					pal_n_q <= clamp_entries(cfg.wdata[NENT_W-1:0]);
				end
				CFG_FRAME_WIDTH: begin
					width_q <= cfg.wdata[DIM_W-1:0];
					total_q <= frame_pixels(cfg.wdata[DIM_W-1:0], height_q);
				end
				CFG_FRAME_HEIGHT: begin
					height_q <= cfg.wdata[DIM_W-1:0];
					total_q  <= frame_pixels(width_q, cfg.wdata[DIM_W-1:0]);
				end
				CFG_ZERO_BG: begin
					zero_bg_q <= cfg.wdata[0];
				end
				CFG_FILL_COLOR: begin
					fill_color_q <= cfg.wdata[COLOR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign regs.pal_n      = pal_n_q;
	assign regs.zero_bg    = zero_bg_q;
	assign regs.fill_color = fill_color_q;
	assign regs.total      = total_q;

endmodule

// ===== design/prfd_front.sv =====
// Front end: accepts items, resolves palette index and run length, issues queue commands.
module prfd_front
	import prfd_pkg::*;
(
	prfd_item_if.sink   item,
	input  cfg_t        regs,
	input  logic        q_ready,
	output logic        q_valid,
	output op_t         q_data
);

	logic [NENT_W-1:0] idx_ext;
	logic [BYTE_W-1:0] idx_clamped;
	logic              slot_ok;

	// Take items whenever the queue has room
	assign item.ready = q_ready;

	// Clamp the colour index to the last valid palette entry
	always_comb begin
		idx_ext = NENT_W'(item.pixel_index);
		if (idx_ext >= regs.pal_n) begin
			idx_clamped = BYTE_W'(regs.pal_n - NENT_W'(1));
		end else begin
			idx_clamped = item.pixel_index;
		end
		slot_ok = (NENT_W'(item.entry_slot) < NENT_W'(PALETTE_DEPTH));
	end

	// Classify the item; drop unused codes and out-of-range palette writes
	always_comb begin
		q_data.kind   = OP_PAL;
		q_data.addr   = item.entry_slot;
		q_data.color  = item.entry_color;
		q_data.run    = (item.run_count == '0) ? BYTE_W'(1) : item.run_count;
		q_data.use_bg = 1'b0;
		q_valid       = 1'b0;
		unique case (item.func)
			FUNC_PAL_WRITE: begin
				q_valid = item.valid && slot_ok;
			end
			FUNC_RUN: begin
				q_data.kind   = OP_RUN;
				q_data.addr   = idx_clamped;
				q_data.use_bg = regs.zero_bg && (item.pixel_index == '0);
				q_valid       = item.valid;
			end
			FUNC_FRAME_END: begin
				q_data.kind   = OP_END;
				q_data.use_bg = 1'b1;
				q_valid       = item.valid;
			end
			default: begin
				q_valid = 1'b0;
			end
		endcase
	end

endmodule

// ===== design/prfd_queue.sv =====
// Short command queue between the front and back ends.
module prfd_queue
	import prfd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  op_t  push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output op_t  pop_data
);

	op_t            slots_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (count_q != (QAW+1)'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + QAW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + QAW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QAW+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QAW+1)'(1);
			end
		end
	end

endmodule

// ===== design/prfd_back.sv =====
// Back end: palette memory, frame position tracking, span clipping and output register.
module prfd_back
	import prfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        regs,
	input  logic        q_valid,
	output logic        q_ready,
	input  op_t         q_data,
	prfd_span_if.source span
);

	logic [COLOR_W-1:0] palette_mem [PALETTE_DEPTH];

	logic [POS_W-1:0]   pos_q;
	logic               v_s1;
	logic [POS_W-1:0]   start_s1;
	logic [POS_W-1:0]   count_s1;
	logic               fe_s1;
	logic               bg_s1;
	logic [COLOR_W-1:0] rd_s1;

	logic               out_v_q;
	logic [START_W-1:0] start_q;
	logic [COUNT_W-1:0] count_q;
	logic [COLOR_W-1:0] color_q;
	logic               fe_q;

	logic               adv1;
	logic               adv2;
	logic               pop;
	logic               full;
	logic [POS_W-1:0]   left;
	logic [POS_W-1:0]   run_ext;
	logic [POS_W-1:0]   clip;
	logic [PAL_AW-1:0]  mem_addr;

	// Stall control of the two stages
	assign adv2    = !out_v_q || span.ready;
	assign adv1    = !v_s1 || adv2;
	assign q_ready = adv1;
	assign pop     = q_valid && adv1;

	// Remaining room in the frame and clipped run
	always_comb begin
		full     = (pos_q >= regs.total);
		left     = regs.total - pos_q;
		run_ext  = POS_W'(q_data.run);
		clip     = (run_ext > left) ? left : run_ext;
		mem_addr = q_data.addr[PAL_AW-1:0];
	end

	// Write palette entries and read the run colour
	always_ff @(posedge clk) begin
		if (pop && q_data.kind == OP_PAL) begin
			palette_mem[mem_addr] <= q_data.color;
		end
		if (pop && q_data.kind == OP_RUN) begin
			rd_s1 <= palette_mem[mem_addr];
		end
	end

	// Hold span geometry of the popped command
	always_ff @(posedge clk) begin
		if (pop) begin
			unique case (q_data.kind)
				OP_RUN: begin
					start_s1 <= pos_q;
					count_s1 <= clip;
					fe_s1    <= 1'b0;
					bg_s1    <= q_data.use_bg;
				end
				OP_END: begin
					start_s1 <= full ? '0 : pos_q;
					count_s1 <= full ? '0 : left;
					fe_s1    <= 1'b1;
					bg_s1    <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Advance the frame position and the stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			if (pop) begin
				unique case (q_data.kind)
					OP_RUN: begin
						v_s1 <= !full;
						if (!full) begin
							pos_q <= pos_q + clip;
						end
					end
					OP_END: begin
						v_s1  <= 1'b1;
						pos_q <= '0;
					end
					default: begin
						v_s1 <= 1'b0;
					end
				endcase
			end else if (adv1) begin
				v_s1 <= 1'b0;
			end
		end
	end

	// Load the output register with the swapped colour
	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			start_q <= START_W'(start_s1);
			count_q <= COUNT_W'(count_s1);
			color_q <= bg_s1 ? swap16(regs.fill_color) : swap16(rd_s1);
			fe_q    <= fe_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv2) begin
			out_v_q <= v_s1;
		end
	end

	assign span.valid      = out_v_q;
	assign span.span_start = start_q;
	assign span.span_count = count_q;
	assign span.span_color = color_q;
	assign span.frame_end  = fe_q;

endmodule
